>>> rtl/ssup_pkg.sv
package ssup_pkg;

  localparam int unsigned SampleW = 16;
  localparam int unsigned PosW    = 16;
  localparam int unsigned WinLen  = 5;
  localparam int unsigned CountW  = 3;

  localparam logic [SampleW-1:0] ThreshReset = 16'd300;

  // One queue entry: a single corrected sample, or a whole window flush
  typedef struct packed {
    logic [WinLen-1:0][SampleW-1:0] samples;
    logic [CountW-1:0]              count;
    logic                           last;
  } ssup_entry_t;

endpackage

>>> rtl/ssup_front.sv
module ssup_front
  import ssup_pkg::*;
#(
  parameter int unsigned SCAN_END = 1020
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [SampleW-1:0] cfg_wdata_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [SampleW-1:0] in_sample_i,
  input  logic               in_last_i,
  input  logic               q_full_i,
  output logic               q_push_o,
  output ssup_entry_t        q_entry_o
);

  localparam int unsigned ScanLim = SCAN_END + 2;

  logic [WinLen-1:0][SampleW-1:0] win_q, win_d;
  logic [CountW-1:0]              fill_q, fill_d;
  logic [PosW-1:0]                pos_q, pos_d;
  logic [SampleW-1:0]             thr_q;

  logic [WinLen-1:0][SampleW-1:0] w, c;
  logic accept, full5, check_en;
  logic o10, o01, o12, o21, o23, o32, o43, o34;
  logic r1, r2, r3;

  function automatic logic over(logic [SampleW-1:0] x, logic [SampleW-1:0] y,
                                logic [SampleW-1:0] t);
    logic [SampleW-1:0] diff;
    diff = x - y;
    return (x > y) && (diff > t);
  endfunction

  assign in_ready_o = !q_full_i;
  assign accept     = in_valid_i && in_ready_o;
  assign full5      = (fill_q == CountW'(WinLen - 1));
  assign check_en   = full5 && (pos_q >= PosW'(4)) && (32'(pos_q) <= ScanLim) &&
                      (pos_q != '1);

  always_comb begin
    w = win_q;
    w[fill_q] = in_sample_i;
  end

  assign o10 = over(w[1], w[0], thr_q);
  assign o01 = over(w[0], w[1], thr_q);
  assign o12 = over(w[1], w[2], thr_q);
  assign o21 = over(w[2], w[1], thr_q);
  assign o23 = over(w[2], w[3], thr_q);
  assign o32 = over(w[3], w[2], thr_q);
  assign o43 = over(w[4], w[3], thr_q);
  assign o34 = over(w[3], w[4], thr_q);

  // Each rule leaves a[p] equal to a[p-1], which blocks the later rules,
  // so all three can be judged on the uncorrected window.
  assign r1 = (o10 && o12) || (o01 && o21);
  assign r2 = (o10 && o23) || (o01 && o32);
  assign r3 = (o10 && o43) || (o01 && o34);

  always_comb begin
    c = w;
    if (check_en) begin
      priority if (r1) begin
        c[1] = w[0];
      end else if (r2) begin
        c[1] = w[0];
        c[2] = w[0];
      end else if (r3) begin
        c[1] = w[0];
        c[2] = w[0];
        c[3] = w[0];
      end
    end
  end

  always_comb begin
    win_d  = win_q;
    fill_d = fill_q;
    pos_d  = pos_q;
    if (accept) begin
      if (full5) begin
        win_d  = {SampleW'(0), c[4], c[3], c[2], c[1]};
        fill_d = fill_q;
      end else begin
        win_d  = w;
        fill_d = fill_q + CountW'(1);
      end
      pos_d = (pos_q != '1) ? pos_q + PosW'(1) : pos_q;
      if (in_last_i) begin
        fill_d = '0;
        pos_d  = '0;
      end
    end
  end

  assign q_push_o          = accept && (full5 || in_last_i);
  assign q_entry_o.samples = full5 ? c : w;
  assign q_entry_o.count   = in_last_i ? fill_q + CountW'(1) : CountW'(1);
  assign q_entry_o.last    = in_last_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q <= '0;
      pos_q  <= '0;
      thr_q  <= ThreshReset;
    end else begin
      fill_q <= fill_d;
      pos_q  <= pos_d;
      if (cfg_we_i) begin
        thr_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    win_q <= win_d;
  end

endmodule

>>> rtl/ssup_queue.sv
module ssup_queue
  import ssup_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push_i,
  input  ssup_entry_t push_entry_i,
  output logic        full_o,
  input  logic        pop_i,
  output ssup_entry_t head_o,
  output logic        empty_o
);

  ssup_entry_t mem_q [2];
  logic        wr_ptr_q, rd_ptr_q;
  logic [1:0]  cnt_q;

  assign full_o  = (cnt_q == 2'd2);
  assign empty_o = (cnt_q == 2'd0);
  assign head_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= !wr_ptr_q;
      end
      if (pop_i) begin
        rd_ptr_q <= !rd_ptr_q;
      end
      unique case ({push_i, pop_i})
        2'b10:   cnt_q <= cnt_q + 2'd1;
        2'b01:   cnt_q <= cnt_q - 2'd1;
        default: cnt_q <= cnt_q;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_entry_i;
    end
  end

endmodule

>>> rtl/ssup_back.sv
module ssup_back
  import ssup_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  ssup_entry_t        head_i,
  input  logic               empty_i,
  output logic               pop_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [SampleW-1:0] out_sample_o,
  output logic               out_last_o
);

  logic [CountW-1:0]  idx_q;
  logic               valid_q;
  logic [SampleW-1:0] sample_q;
  logic               last_q;
  logic               out_free, emit, entry_done;

  assign out_free   = !valid_q || out_ready_i;
  assign emit       = !empty_i && out_free;
  assign entry_done = (idx_q == head_i.count - CountW'(1));
  assign pop_o      = emit && entry_done;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q   <= '0;
      valid_q <= 1'b0;
    end else begin
      if (emit) begin
        valid_q <= 1'b1;
        idx_q   <= entry_done ? '0 : idx_q + CountW'(1);
      end else if (out_ready_i) begin
        valid_q <= 1'b0;
      end
    end
  end

  // Hold the result register until the receiver takes it
  always_ff @(posedge clk_i) begin
    if (emit) begin
      sample_q <= head_i.samples[idx_q];
      last_q   <= head_i.last && entry_done;
    end
  end

  assign out_valid_o  = valid_q;
  assign out_sample_o = sample_q;
  assign out_last_o   = last_q;

endmodule

>>> rtl/sample_spike_suppressor.sv
// Spike suppressor for a block of 16-bit ADC samples.
// Input stream s_axis: one sample per transfer, tlast on the final sample of
// a block. Output stream m_axis: the corrected samples in block order, tlast
// on the final one. cfg_we_i/cfg_wdata_i write the spike threshold; write it
// only while the block is idle.
// The first four samples of a block give no output; each later sample
// releases the sample four positions back. The tlast sample also flushes all
// held samples, so it releases up to five results.
// Throughput: one sample per cycle in and out, while the queue has room and
// the receiver is ready. At a block end the output serializer drains the
// flushed samples one sample per cycle; the two-entry queue between window
// and serializer lets the input keep going while the next block fills its
// window. Blocks shorter than five samples sent back to back can fill the
// queue and drop s_axis_tready until the pending flush drains.
// A released sample is written into the queue and then into the output
// register before it is valid on m_axis.
// Reset: threshold returns to 300 and the window empties.
// A stalled receiver holds the output register; the queue then fills and
// s_axis_tready drops until the receiver resumes.
module sample_spike_suppressor
  import ssup_pkg::*;
#(
  parameter int unsigned SCAN_END = 1020
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [SampleW-1:0] cfg_wdata_i,
  input  logic               s_axis_tvalid,
  output logic               s_axis_tready,
  input  logic [15:0]        s_axis_tdata,  // [15:0] sample
  input  logic               s_axis_tlast,  // block_end
  output logic               m_axis_tvalid,
  input  logic               m_axis_tready,
  output logic [15:0]        m_axis_tdata,  // [15:0] clean_sample
  output logic               m_axis_tlast   // last_out
);

  logic        q_push, q_full, q_pop, q_empty;
  ssup_entry_t q_entry, q_head;

  ssup_front #(
    .SCAN_END(SCAN_END)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .in_sample_i(s_axis_tdata),
    .in_last_i  (s_axis_tlast),
    .q_full_i   (q_full),
    .q_push_o   (q_push),
    .q_entry_o  (q_entry)
  );

  ssup_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (q_push),
    .push_entry_i(q_entry),
    .full_o      (q_full),
    .pop_i       (q_pop),
    .head_o      (q_head),
    .empty_o     (q_empty)
  );

  ssup_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .head_i      (q_head),
    .empty_i     (q_empty),
    .pop_o       (q_pop),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_sample_o(m_axis_tdata),
    .out_last_o  (m_axis_tlast)
  );

  a_no_push_when_full : assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_push |-> !q_full)
    else $error("queue overflow");

  a_no_pop_when_empty : assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop |-> !q_empty)
    else $error("queue underflow");

  a_entry_count_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_push |-> (q_entry.count != '0) && (q_entry.count <= CountW'(WinLen)))
    else $error("queue entry count out of range");

  a_single_not_last : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (q_push && !q_entry.last) |-> (q_entry.count == CountW'(1)))
    else $error("non-final entry carries more than one sample");

endmodule
